// File: rtl/dasb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dasb_pkg
// Shared types, constants and width helpers of the digit average score binner.
// ----------------------------------------------------------------------------
package dasb_pkg;

    localparam int TOTAL_W         = 20;
    localparam int STEP_W          = 16;
    localparam int WEIGHT_W        = 8;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 20;
    localparam int FIELD_IDX_W     = 3;
    localparam int WEIGHTED_FIELDS = 5;

    // register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WEIGHT_ONE   = 3'd0,
        REG_WEIGHT_TWO   = 3'd1,
        REG_WEIGHT_THREE = 3'd2,
        REG_WEIGHT_FOUR  = 3'd3,
        REG_WEIGHT_FIVE  = 3'd4,
        REG_LOW_BOUND    = 3'd5,
        REG_BIN_STEP     = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic [WEIGHTED_FIELDS-1:0][WEIGHT_W-1:0] weight;
        logic signed [TOTAL_W-1:0]                low_bound;
        logic [STEP_W-1:0]                        bin_step;
    } cfg_t;

    // widths that follow from the longest field
    function automatic int cnt_width(int max_len);
        return $clog2(max_len + 1);
    endfunction

    function automatic int sum_width(int max_len);
        return cnt_width(max_len) + 9;
    endfunction

    // job layout: last, field index, count, sum
    function automatic int job_width(int max_len);
        return sum_width(max_len) + cnt_width(max_len) + FIELD_IDX_W + 1;
    endfunction

endpackage
`default_nettype wire

// File: rtl/digit_average_score_binner.sv
`default_nettype none
// ----------------------------------------------------------------------------
// digit_average_score_binner
// Scores records character by character and sorts each record into a bin.
// ----------------------------------------------------------------------------
//
//  channel | handshake              | payload
//  --------+------------------------+------------------------------------------
//  in      | in_valid / in_stall    | char_code, field_index, field_end,
//          |                        | record_end
//  out     | out_valid / out_stall  | bin_index, total_score
//  cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// the front takes one character item per cycle while the job queue has room
// each closed field passes the back through a divide of one bit per cycle, a
//   multiply and a saturating add; a record end adds a threshold scan
// the four-entry job queue hides the divide behind the characters of the next field
// rst_n clears the accumulators, the queue, the record total and the registers
// to their reset values; a stalled result holds while the back keeps working
//
module digit_average_score_binner import dasb_pkg::*; #(
    parameter int MAX_FIELD_LEN = 1024,
    parameter int BINS          = 50
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire logic [7:0]              char_code,
    input  wire logic [FIELD_IDX_W-1:0]  field_index,
    input  wire logic                    field_end,
    input  wire logic                    record_end,
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output logic      [5:0]              bin_index,
    output logic signed [TOTAL_W-1:0]    total_score,
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [CFG_DATA_W-1:0]   cfg_data
);

    localparam int JOB_W       = job_width(MAX_FIELD_LEN);
    localparam int QUEUE_DEPTH = 4;

    // configuration registers; the user writes them only while idle (not enforced)
    cfg_t cfg_reg, cfg_next;

    // front to back job queue
    logic             q_push;
    logic             q_pop;
    logic             q_full;
    logic             q_empty;
    logic [JOB_W-1:0] q_wdata;
    logic [JOB_W-1:0] q_rdata;

    // writes are always taken
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index) inside
                [REG_WEIGHT_ONE:REG_WEIGHT_FIVE]:
                begin
                    cfg_next.weight[cfg_index] = cfg_data[WEIGHT_W-1:0];
                end
                REG_LOW_BOUND:
                begin
                    cfg_next.low_bound = $signed(cfg_data[TOTAL_W-1:0]);
                end
                REG_BIN_STEP:
                begin
                    cfg_next.bin_step = cfg_data[STEP_W-1:0];
                end
                default:
                begin
                    // indexes past the last register are dropped
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.weight    <= {WEIGHTED_FIELDS{8'd51}};
            cfg_reg.low_bound <= 20'sd6400;
            cfg_reg.bin_step  <= 16'd154;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // character accumulation, one job per closed field
    dasb_front #(
        .MAX_FIELD_LEN (MAX_FIELD_LEN)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .char_code   (char_code),
        .field_index (field_index),
        .field_end   (field_end),
        .record_end  (record_end),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_wdata     (q_wdata)
    );

    dasb_queue #(
        .WIDTH (JOB_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .pop   (q_pop),
        .rdata (q_rdata),
        .full  (q_full),
        .empty (q_empty)
    );

    // divide, weight, accumulate and bin
    dasb_back #(
        .MAX_FIELD_LEN (MAX_FIELD_LEN),
        .BINS          (BINS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .q_empty     (q_empty),
        .q_rdata     (q_rdata),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .bin_index   (bin_index),
        .total_score (total_score)
    );

endmodule
`default_nettype wire

// File: rtl/dasb_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dasb_queue
// Small register queue that parts the character front from the field back.
// ----------------------------------------------------------------------------
module dasb_queue #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] rdata,
    output logic                  full,
    output logic                  empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule
`default_nettype wire

// File: rtl/dasb_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dasb_front
// Takes characters, keeps the field sum and count, and queues a job per field.
// ----------------------------------------------------------------------------
module dasb_front import dasb_pkg::*; #(
    parameter  int MAX_FIELD_LEN = 1024,
    localparam int CNT_W         = cnt_width(MAX_FIELD_LEN),
    localparam int SUM_W         = sum_width(MAX_FIELD_LEN),
    localparam int JOB_W         = job_width(MAX_FIELD_LEN)
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [7:0]             char_code,
    input  wire logic [FIELD_IDX_W-1:0] field_index,
    input  wire logic                   field_end,
    input  wire logic                   record_end,
    input  wire logic                   q_full,
    output logic                        q_push,
    output logic      [JOB_W-1:0]       q_wdata
);

    localparam logic signed [8:0] CHAR_BIAS = 9'sd48;

    // same layout as in dasb_back
    typedef struct packed {
        logic                   last;
        logic [FIELD_IDX_W-1:0] idx;
        logic [CNT_W-1:0]       cnt;
        logic signed [SUM_W-1:0] sum;
    } job_t;

    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic signed [8:0]       char_val;
    logic                    take;
    logic signed [SUM_W-1:0] sum_acc;
    logic [CNT_W-1:0]        cnt_acc;
    logic                    accept;
    logic                    close;
    job_t                    job;

    assign char_val = $signed({1'b0, char_code}) - CHAR_BIAS;
    // characters past the longest field are dropped
    assign take     = (cnt_reg < CNT_W'(MAX_FIELD_LEN));
    assign sum_acc  = take ? sum_reg + SUM_W'(char_val) : sum_reg;
    assign cnt_acc  = take ? cnt_reg + 1'b1 : cnt_reg;

    assign in_stall = q_full;
    assign accept   = in_valid && !in_stall;
    assign close    = field_end || record_end;
    assign q_push   = accept && close;

    always_comb
    begin
        job.last = record_end;
        job.idx  = field_index;
        job.cnt  = cnt_acc;
        job.sum  = sum_acc;
    end

    assign q_wdata = job;

    always_comb
    begin
        sum_next = sum_reg;
        cnt_next = cnt_reg;
        if (accept)
        begin
            if (close)
            begin
                sum_next = '0;
                cnt_next = '0;
            end
            else
            begin
                sum_next = sum_acc;
                cnt_next = cnt_acc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            sum_reg <= sum_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule
`default_nettype wire

// File: rtl/dasb_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dasb_back
// Divides each field job, weights it into the record total, bins the record.
// ----------------------------------------------------------------------------
module dasb_back import dasb_pkg::*; #(
    parameter  int MAX_FIELD_LEN = 1024,
    parameter  int BINS          = 50,
    localparam int CNT_W         = cnt_width(MAX_FIELD_LEN),
    localparam int SUM_W         = sum_width(MAX_FIELD_LEN),
    localparam int JOB_W         = job_width(MAX_FIELD_LEN)
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire cfg_t               cfg,
    input  wire logic               q_empty,
    input  wire logic [JOB_W-1:0]   q_rdata,
    output logic                    q_pop,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic      [5:0]         bin_index,
    output logic signed [TOTAL_W-1:0] total_score
);

    localparam int BIN_W  = $clog2(BINS);
    localparam int TH_W   = STEP_W + BIN_W + 5;
    localparam int PROD_W = SUM_W + WEIGHT_W + 2;
    localparam int DSTP_W = $clog2(SUM_W);
    localparam logic signed [PROD_W:0] SAT_HI = (PROD_W + 1)'(524287);
    localparam logic signed [PROD_W:0] SAT_LO = -(PROD_W + 1)'(524288);

    typedef struct packed {
        logic                   last;
        logic [FIELD_IDX_W-1:0] idx;
        logic [CNT_W-1:0]       cnt;
        logic signed [SUM_W-1:0] sum;
    } job_t;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_DIV    = 7'b0000010,
        S_MUL    = 7'b0000100,
        S_ACC    = 7'b0001000,
        S_BSTART = 7'b0010000,
        S_BIN    = 7'b0100000,
        S_OUT    = 7'b1000000
    } state_t;

    state_t                    state_reg, state_next;
    logic                      last_reg, last_next;
    logic                      neg_reg, neg_next;
    logic [WEIGHT_W-1:0]       weight_reg, weight_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic [CNT_W-1:0]          rem_reg, rem_next;
    logic [SUM_W-1:0]          quo_reg, quo_next;
    logic [DSTP_W-1:0]         dstep_reg, dstep_next;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic signed [TOTAL_W-1:0] total_reg, total_next;
    logic signed [TH_W-1:0]    th_reg, th_next;
    logic [BIN_W-1:0]          k_reg, k_next;
    logic [BIN_W-1:0]          bin_reg, bin_next;
    logic                      out_valid_reg, out_valid_next;
    logic [5:0]                out_bin_reg, out_bin_next;
    logic signed [TOTAL_W-1:0] out_total_reg, out_total_next;

    job_t                      job;
    logic                      field_ok;
    logic [SUM_W-1:0]          mag;
    logic [CNT_W:0]            rem_sh;
    logic [CNT_W:0]            rem_diff;
    logic                      rem_ge;
    logic signed [SUM_W:0]     avg;
    logic signed [PROD_W:0]    acc_sum;
    logic signed [TH_W-1:0]    step_ext;

    assign job      = job_t'(q_rdata);
    // identifier and unknown fields, and empty fields, add nothing
    assign field_ok = (job.cnt != '0) && (job.idx != '0)
                   && (job.idx <= FIELD_IDX_W'(WEIGHTED_FIELDS));
    assign mag      = job.sum[SUM_W-1] ? SUM_W'(-job.sum) : SUM_W'(job.sum);

    // one restoring division step per cycle
    assign rem_sh   = {rem_reg, quo_reg[SUM_W-1]};
    assign rem_diff = rem_sh - {1'b0, cnt_reg};
    assign rem_ge   = (rem_sh >= {1'b0, cnt_reg});

    assign avg      = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});
    assign acc_sum  = (PROD_W + 1)'(total_reg) + (PROD_W + 1)'(prod_reg);
    assign step_ext = TH_W'($signed({1'b0, cfg.bin_step}));

    assign out_valid   = out_valid_reg;
    assign bin_index   = out_bin_reg;
    assign total_score = out_total_reg;

    always_comb
    begin
        state_next     = state_reg;
        last_next      = last_reg;
        neg_next       = neg_reg;
        weight_next    = weight_reg;
        cnt_next       = cnt_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        dstep_next     = dstep_reg;
        prod_next      = prod_reg;
        total_next     = total_reg;
        th_next        = th_reg;
        k_next         = k_reg;
        bin_next       = bin_reg;
        out_valid_next = out_valid_reg;
        out_bin_next   = out_bin_reg;
        out_total_next = out_total_reg;
        q_pop          = 1'b0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop       = 1'b1;
                    last_next   = job.last;
                    neg_next    = job.sum[SUM_W-1];
                    weight_next = cfg.weight[FIELD_IDX_W'(job.idx - 1'b1)];
                    cnt_next    = job.cnt;
                    rem_next    = '0;
                    quo_next    = mag;
                    dstep_next  = '0;
                    if (field_ok)
                    begin
                        state_next = S_DIV;
                    end
                    else if (job.last)
                    begin
                        state_next = S_BSTART;
                    end
                end
            end
            S_DIV:
            begin
                rem_next   = rem_ge ? rem_diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
                quo_next   = {quo_reg[SUM_W-2:0], rem_ge};
                dstep_next = dstep_reg + 1'b1;
                if (dstep_reg == DSTP_W'(SUM_W - 1))
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                prod_next  = PROD_W'(avg) * PROD_W'($signed({1'b0, weight_reg}));
                state_next = S_ACC;
            end
            S_ACC:
            begin
                if (acc_sum > SAT_HI)
                begin
                    total_next = TOTAL_W'(SAT_HI);
                end
                else if (acc_sum < SAT_LO)
                begin
                    total_next = TOTAL_W'(SAT_LO);
                end
                else
                begin
                    total_next = TOTAL_W'(acc_sum);
                end
                state_next = last_reg ? S_BSTART : S_IDLE;
            end
            S_BSTART:
            begin
                th_next    = TH_W'(cfg.low_bound) + step_ext;
                k_next     = BIN_W'(1);
                bin_next   = '0;
                state_next = S_BIN;
            end
            S_BIN:
            begin
                // one threshold per cycle
                if (TH_W'(total_reg) >= th_reg)
                begin
                    bin_next = bin_reg + 1'b1;
                end
                th_next = th_reg + step_ext;
                k_next  = k_reg + 1'b1;
                if (k_reg == BIN_W'(BINS - 1))
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_bin_next   = 6'(bin_reg);
                    out_total_next = total_reg;
                    total_next     = '0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
            dstep_reg     <= '0;
            k_reg         <= '0;
            bin_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
            dstep_reg     <= dstep_next;
            k_reg         <= k_next;
            bin_reg       <= bin_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg      <= last_next;
        neg_reg       <= neg_next;
        weight_reg    <= weight_next;
        cnt_reg       <= cnt_next;
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        prod_reg      <= prod_next;
        th_reg        <= th_next;
        out_bin_reg   <= out_bin_next;
        out_total_reg <= out_total_next;
    end

`ifndef SYNTHESIS
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (state_reg == S_IDLE) && !q_empty)
        else $error("job popped outside idle or from an empty queue");

    a_rem_below_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (rem_reg < cnt_reg))
        else $error("partial remainder reached the divisor");

    a_bin_below_k: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_BIN) |-> (k_reg != '0) && (bin_reg < k_reg))
        else $error("bin count ran ahead of the threshold scan");

    a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("result item raised outside the output state");
`endif

endmodule
`default_nettype wire

// File: bench/digit_average_score_binner_test.sv
// ----------------------------------------------------------------------------
// digit_average_score_binner_test
// Self-checking bench: streams records of character items into the binner,
// scores every accepted item in its own record scorer and compares each
// result item against the oldest score still owed.
// ----------------------------------------------------------------------------
module digit_average_score_binner_test;
    import dasb_pkg::*;

    localparam int MAX_LEN      = 1024;
    localparam int BIN_COUNT    = 50;
    localparam int CHAR_BIAS    = 48;
    localparam int TOTAL_TOP    = 524287;
    localparam int TOTAL_BOTTOM = -524288;
    localparam int PHASE_ITEMS  = 115;
    localparam int MIN_RECORDS  = 30;
    localparam int DRAIN_CYCLES = 200;
    localparam int HOLD_CYCLES  = 1000;
    localparam int MAX_REPORTS  = 10;

    localparam logic [7:0] CHAR_ZERO = 8'd48;
    localparam logic [7:0] CHAR_TOP  = 8'hFF;
    localparam logic [7:0] CHAR_LOW  = 8'h00;

    // index beyond the register file, writes to it must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

    typedef struct packed {
        logic [5:0]                bin;
        logic signed [TOTAL_W-1:0] total;
    } record_score_t;

    // ------------------------------------------------------------------------
    // record scorer: own copy of registers and accumulators, plus the queue of
    // scores the block still owes
    // ------------------------------------------------------------------------
    class record_scorer;
        logic [WEIGHT_W-1:0]       weight [WEIGHTED_FIELDS];
        logic signed [TOTAL_W-1:0] low_bound;
        logic [STEP_W-1:0]         bin_step;
        int                        field_sum;
        int                        field_count;
        int                        record_total;
        record_score_t             pending_scores [$];
        int                        faults;
        int                        scores_seen;

        function new();
            foreach (weight[i])
                weight[i] = 8'd51;
            low_bound    = 20'sd6400;
            bin_step     = 16'd154;
            field_sum    = 0;
            field_count  = 0;
            record_total = 0;
            faults       = 0;
            scores_seen  = 0;
        endfunction

        function void note_fault(string msg);
            faults++;
            if (faults <= MAX_REPORTS)
                $display("%s", msg);
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_WEIGHT_ONE, REG_WEIGHT_TWO, REG_WEIGHT_THREE,
                REG_WEIGHT_FOUR, REG_WEIGHT_FIVE: weight[idx] = data[WEIGHT_W-1:0];
                REG_LOW_BOUND:                    low_bound = data;
                REG_BIN_STEP:                     bin_step = data[STEP_W-1:0];
                default:                          ;
            endcase
        endfunction

        // average of the field times its weight, saturated into the total
        function void close_field(logic [FIELD_IDX_W-1:0] idx);
            int     avg;
            longint sum;
            if (field_count != 0 && idx >= 1 && idx <= WEIGHTED_FIELDS)
            begin
                avg = field_sum / field_count;
                sum = longint'(record_total) + longint'(avg) * longint'(weight[idx - 1]);
                if (sum > TOTAL_TOP)
                    sum = TOTAL_TOP;
                if (sum < TOTAL_BOTTOM)
                    sum = TOTAL_BOTTOM;
                record_total = int'(sum);
            end
            field_sum   = 0;
            field_count = 0;
        endfunction

        function void take_char(logic [7:0] code, logic [FIELD_IDX_W-1:0] idx,
                                bit fend, bit rend);
            record_score_t score;
            longint        threshold;
            int            bin;
            if (field_count < MAX_LEN)
            begin
                field_sum += int'(code) - CHAR_BIAS;
                field_count++;
            end
            if (fend || rend)
                close_field(idx);
            if (rend)
            begin
                bin = 0;
                for (int k = 1; k < BIN_COUNT; k++)
                begin
                    threshold = longint'(low_bound) + longint'(k) * longint'(bin_step);
                    if (longint'(record_total) >= threshold)
                        bin++;
                end
                score.bin   = bin[5:0];
                score.total = record_total[TOTAL_W-1:0];
                pending_scores.push_back(score);
                record_total = 0;
                field_sum    = 0;
                field_count  = 0;
            end
        endfunction

        function void check_score(logic [5:0] bin, logic signed [TOTAL_W-1:0] total);
            record_score_t owed;
            scores_seen++;
            if (pending_scores.size() == 0)
            begin
                note_fault($sformatf("score %0d: unexpected item, bin %0d total %0d",
                                     scores_seen, bin, total));
                return;
            end
            owed = pending_scores.pop_front();
            if (owed.bin !== bin || owed.total !== total)
                note_fault($sformatf("score %0d: expected bin %0d total %0d, got bin %0d total %0d",
                                     scores_seen, owed.bin, owed.total, bin, total));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // block under test
    // ------------------------------------------------------------------------
    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_stall;
    logic [7:0]              char_code;
    logic [FIELD_IDX_W-1:0]  field_index;
    logic                    field_end;
    logic                    record_end;
    logic                    out_valid;
    logic                    out_stall;
    logic [5:0]              bin_index;
    logic signed [TOTAL_W-1:0] total_score;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;

    digit_average_score_binner #(
        .MAX_FIELD_LEN (MAX_LEN),
        .BINS          (BIN_COUNT)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .char_code   (char_code),
        .field_index (field_index),
        .field_end   (field_end),
        .record_end  (record_end),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .bin_index   (bin_index),
        .total_score (total_score),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    record_scorer board;

    int items_sent;     // accepted character items, all phases
    int records_sent;   // records sent in the random phases
    int gap_odds;       // sender idles after an item with odds 1 in gap_odds, 0 = never
    bit quiet;          // last phase: neither side idles
    int hold_cycles;    // long receiver hold-off, counted down by the receiver

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // generous bound: the slowest legal run stays far below this
    initial
    begin
        #10_000_000;
        $display("status: fail");
        $finish;
    end

    // ------------------------------------------------------------------------
    // receiver: checks every accepted result item, then picks the next stall
    // value; random stall bursts broken up by calm stretches
    // ------------------------------------------------------------------------
    initial
    begin
        int stall_left;
        int calm_left;
        stall_left = 0;
        calm_left  = 0;
        out_stall  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
                board.check_score(bin_index, total_score);
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                out_stall <= 1'b1;
            end
            else if (quiet)
                out_stall <= 1'b0;
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (calm_left > 0)
            begin
                calm_left--;
                out_stall <= 1'b0;
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                stall_left = $urandom_range(1, 18) - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                calm_left = $urandom_range(0, 40);
                out_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------------

    // offer one character item and hold it until accepted; valid stays high
    // into the next item unless an idle burst follows
    task automatic offer_char(input logic [7:0] code, input logic [FIELD_IDX_W-1:0] idx,
                              input bit fend, input bit rend);
        int gap;
        in_valid    <= 1'b1;
        char_code   <= code;
        field_index <= idx;
        field_end   <= fend;
        record_end  <= rend;
        do
            @(posedge clk);
        while (in_stall);
        board.take_char(code, idx, fend, rend);
        items_sent++;
        if (!quiet && gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
        begin
            gap = $urandom_range(1, 18);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // mostly digits, sometimes any byte so the value runs over -48..207
    function automatic logic [7:0] pick_char();
        if ($urandom_range(0, 19) < 17)
            return CHAR_ZERO + 8'($urandom_range(0, 9));
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic void pick_gap_odds();
        gap_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 10);
    endfunction

    // record of single-character fields in the weighted range; a negative
    // code picks a random character per field
    task automatic burst_record(input int fields, input int code);
        pick_gap_odds();
        for (int i = 0; i < fields; i++)
            offer_char(code < 0 ? pick_char() : code[7:0],
                       FIELD_IDX_W'($urandom_range(1, WEIGHTED_FIELDS)), 1'b1, i == fields - 1);
    endtask

    task automatic send_record();
        int  style;
        int  nfields;
        int  len;
        bit  last;
        logic [FIELD_IDX_W-1:0] idx;
        style = $urandom_range(0, 15);
        pick_gap_odds();
        if (style < 11)
        begin
            // well-formed: identifier then the five weighted fields in order;
            // the record end sometimes comes without a field end
            for (int f = 0; f <= WEIGHTED_FIELDS; f++)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 20) : $urandom_range(1, 5);
                for (int c = 0; c < len; c++)
                begin
                    last = (c == len - 1);
                    offer_char(pick_char(), FIELD_IDX_W'(f),
                               last && (f < WEIGHTED_FIELDS || $urandom_range(0, 3) != 0),
                               last && f == WEIGHTED_FIELDS);
                end
            end
        end
        else if (style < 15)
        begin
            // broken: any field index, repeats, unknown fields, merged fields
            nfields = $urandom_range(1, 10);
            for (int f = 0; f < nfields; f++)
            begin
                idx = FIELD_IDX_W'($urandom_range(0, 7));
                len = $urandom_range(1, 6);
                for (int c = 0; c < len; c++)
                begin
                    last = (c == len - 1);
                    offer_char(8'($urandom_range(0, 255)), idx,
                               last && $urandom_range(0, 7) != 0,
                               last && f == nfields - 1);
                end
            end
        end
        else
            // many extreme fields, drives the total into saturation
            burst_record($urandom_range(20, 60), $urandom_range(0, 1) ? CHAR_TOP : CHAR_LOW);
        records_sent++;
    endtask

    // ------------------------------------------------------------------------
    // configuration side, only used while the block is idle
    // ------------------------------------------------------------------------

    // wait until no score is owed, then let the back end run out of
    // field-close work that produces nothing
    task automatic wait_idle();
        while (board.pending_scores.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // cfg_valid stays high across a batch, the caller lowers it
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        board.write_reg(idx, data);
    endtask

    task automatic configure(input int phase);
        logic [CFG_DATA_W-1:0] w [WEIGHTED_FIELDS];
        logic [CFG_DATA_W-1:0] low;
        logic [STEP_W-1:0]     step;
        // weights keep random upper data bits, the register takes the low byte
        foreach (w[i])
            w[i] = CFG_DATA_W'($urandom_range(0, 20'hFFFFF));
        low  = CFG_DATA_W'($urandom_range(0, 6000) - 2000);
        step = STEP_W'($urandom_range(1, 200));
        case (phase)
            1:
            begin
                // largest weights, lowest edge, widest bins
                foreach (w[i])
                    w[i] = 20'hFFFFF;
                low  = 20'h80000;
                step = 16'hFFFF;
                write_reg(REG_SPARE, CFG_DATA_W'($urandom_range(0, 20'hFFFFF)));
            end
            2:
            begin
                // zero weights, highest edge, zero bin step
                foreach (w[i])
                    w[i] = 20'hFFF00;
                low  = 20'h7FFFF;
                step = '0;
            end
            4: step = 16'd1;
            6: step = '0;
            default: ;
        endcase
        write_reg(REG_WEIGHT_ONE,   w[0]);
        write_reg(REG_WEIGHT_TWO,   w[1]);
        write_reg(REG_WEIGHT_THREE, w[2]);
        write_reg(REG_WEIGHT_FOUR,  w[3]);
        write_reg(REG_WEIGHT_FIVE,  w[4]);
        write_reg(REG_LOW_BOUND,    low);
        write_reg(REG_BIN_STEP,     {4'($urandom_range(0, 15)), step});
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // stimulus phases
    // ------------------------------------------------------------------------

    // reset registers: byte extremes, identifier and unknown fields,
    // truncation of the average both ways, record end without field end
    task automatic directed_records();
        offer_char(CHAR_TOP, 3'd1, 1'b1, 1'b0);
        offer_char(CHAR_LOW, 3'd2, 1'b1, 1'b0);
        offer_char(CHAR_ZERO + 8'd9, 3'd0, 1'b1, 1'b0);
        offer_char(CHAR_ZERO + 8'd7, 3'd6, 1'b1, 1'b0);
        offer_char(CHAR_ZERO + 8'd7, 3'd7, 1'b1, 1'b0);
        offer_char(CHAR_ZERO + 8'd3, 3'd3, 1'b0, 1'b0);
        offer_char(CHAR_ZERO + 8'd4, 3'd3, 1'b1, 1'b0);
        offer_char(CHAR_ZERO - 8'd1, 3'd4, 1'b0, 1'b0);
        offer_char(CHAR_ZERO, 3'd4, 1'b1, 1'b0);
        offer_char(CHAR_ZERO + 8'd8, 3'd5, 1'b0, 1'b1);
        // single-item records: identifier only, unknown field only
        offer_char(CHAR_ZERO + 8'd5, 3'd0, 1'b0, 1'b1);
        offer_char(CHAR_ZERO + 8'd5, 3'd6, 1'b1, 1'b1);
        // a five-field record that stays below the first threshold at reset settings
        for (int i = 0; i < 5; i++)
            offer_char(CHAR_ZERO + 8'd9, FIELD_IDX_W'(i + 1), 1'b1, i == 4);
        in_valid <= 1'b0;
    endtask

    task automatic run_phase(input int phase);
        int  first_item;
        bit  paused;
        first_item = items_sent;
        paused     = 1'b0;
        case (phase)
            1:
            begin
                // saturation at both ends with full weights
                burst_record(11, CHAR_TOP);
                burst_record(45, CHAR_LOW);
            end
            3:
            begin
                // receiver holds off while short fields keep coming, so the
                // job queue fills and the input stalls
                hold_cycles = HOLD_CYCLES;
                repeat (4) burst_record(12, -1);
            end
            default: ;
        endcase
        while (items_sent - first_item < PHASE_ITEMS ||
               (phase == 7 && records_sent < MIN_RECORDS))
        begin
            if (phase == 4 && !paused && items_sent - first_item > PHASE_ITEMS / 2)
            begin
                // sender pause until every owed score is out
                in_valid <= 1'b0;
                do
                    @(posedge clk);
                while (board.pending_scores.size() != 0);
                paused = 1'b1;
            end
            send_record();
        end
        in_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int waited;
        board        = new();
        items_sent   = 0;
        records_sent = 0;
        gap_odds     = 4;
        quiet        = 1'b0;
        hold_cycles  = 0;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        char_code    = '0;
        field_index  = '0;
        field_end    = 1'b0;
        record_end   = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_records();
        for (int phase = 1; phase <= 7; phase++)
        begin
            wait_idle();
            configure(phase);
            quiet = (phase == 7);
            run_phase(phase);
        end

        // drain with a bound, then a quiet tail to catch stray items
        waited = 0;
        while (board.pending_scores.size() != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.pending_scores.size() != 0)
            board.note_fault($sformatf("%0d scores never arrived",
                                       board.pending_scores.size()));

        if (board.faults == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// File: filelist.f
rtl/dasb_pkg.sv
rtl/dasb_queue.sv
rtl/dasb_front.sv
rtl/dasb_back.sv
rtl/digit_average_score_binner.sv
bench/digit_average_score_binner_test.sv
